@@ rtl/matrix_inverse_3x3_defines.svh @@
// Assertion macros for the 3x3 matrix inverse
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MI3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mi3 check failed");

// next-cycle implication
`define MI3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mi3 check failed");

`endif

@@ rtl/mi3_pkg.sv @@
// Shared widths, latencies and types for the 3x3 matrix inverse
package mi3_pkg;

    localparam int ENT_W      = 24;               // Q8.16 entry
    localparam int PROD_W     = 2 * ENT_W;        // entry product
    localparam int ADJ_W      = PROD_W + 1;       // cofactor, signed
    localparam int ADJ_MAG_W  = PROD_W;           // cofactor magnitude
    localparam int SPLIT_W    = ENT_W;            // low part of cofactor in det products
    localparam int PART_W     = ADJ_W;            // each partial product
    localparam int DET_W      = 74;               // determinant, signed
    localparam int DET_MAG_W  = DET_W - 1;
    localparam int FRAC_SH    = 32;               // adj * 2^32 / det
    localparam int BIG_SH     = FRAC_SH - ENT_W;  // quotient >= 2^24 test
    localparam int REM_W      = ADJ_MAG_W + FRAC_SH;
    localparam int QB         = ENT_W;            // quotient bits computed
    localparam int CMP_W      = DET_MAG_W + QB;
    localparam int FRONT_LAT  = 5;
    localparam int DIV_LAT    = 2 + QB + 1;
    localparam int LAT        = FRONT_LAT + DIV_LAT;
    localparam int NENT       = 9;

    localparam logic signed [ENT_W-1:0] Q_MAX = {1'b0, {(ENT_W-1){1'b1}}};
    localparam logic signed [ENT_W-1:0] Q_MIN = {1'b1, {(ENT_W-1){1'b0}}};

    typedef struct packed {
        logic sat;
        logic zero;
    } mi3_flag_t;

endpackage

@@ rtl/mi3_div.sv @@
// Pipelined restoring divider: adj * 2^32 / det, truncated, saturated to Q8.16
module mi3_div
    import mi3_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ADJ_W-1:0] adj,
    input  logic signed [DET_W-1:0] det,
    output logic signed [ENT_W-1:0] quo,
    output mi3_flag_t               flag
);

    logic [ADJ_MAG_W-1:0] amag_reg;
    logic [DET_MAG_W-1:0] dmag_reg;
    logic                 neg0_reg;
    logic                 zero0_reg;

    logic [REM_W-1:0]     rem_reg  [0:QB];
    logic [DET_MAG_W-1:0] den_reg  [0:QB];
    logic [QB-1:0]        q_reg    [0:QB];
    logic                 big_reg  [0:QB];
    logic                 neg_reg  [0:QB];
    logic                 zero_reg [0:QB];

    logic signed [ADJ_W-1:0] adj_neg;
    logic signed [DET_W-1:0] det_neg;

    assign adj_neg = -adj;
    assign det_neg = -det;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            amag_reg  <= adj[ADJ_W-1] ? adj_neg[ADJ_MAG_W-1:0] : adj[ADJ_MAG_W-1:0];
            dmag_reg  <= det[DET_W-1] ? det_neg[DET_MAG_W-1:0] : det[DET_MAG_W-1:0];
            neg0_reg  <= adj[ADJ_W-1] ^ det[DET_W-1];
            zero0_reg <= (det == '0);
        end
    end

    // quotient of 2^24 or more saturates either way, so only 24 bits are resolved
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {amag_reg, {FRAC_SH{1'b0}}};
            den_reg[0]  <= dmag_reg;
            q_reg[0]    <= '0;
            big_reg[0]  <= ({1'b0, amag_reg, {BIG_SH{1'b0}}} >= (REM_W - BIG_SH + 1)'(dmag_reg));
            neg_reg[0]  <= neg0_reg;
            zero_reg[0] <= zero0_reg;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_bit
        localparam int BIT = QB - 1 - j;
        logic [CMP_W-1:0] trial;
        logic [CMP_W-1:0] remx;
        logic             ge;

        assign trial = CMP_W'(den_reg[j]) << BIT;
        assign remx  = CMP_W'(rem_reg[j]);
        assign ge    = (remx >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= ge ? REM_W'(remx - trial) : rem_reg[j];
                q_reg[j+1]    <= q_reg[j] | (QB'(ge) << BIT);
                den_reg[j+1]  <= den_reg[j];
                big_reg[j+1]  <= big_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    logic [QB:0]             qx;
    logic signed [QB:0]      qneg;

    assign qx   = {1'b0, q_reg[QB]};
    assign qneg = -$signed(qx);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag.zero <= zero_reg[QB];
            if (zero_reg[QB])
            begin
                quo      <= '0;
                flag.sat <= 1'b0;
            end
            else if (neg_reg[QB])
            begin
                if (big_reg[QB] || (qx > (QB+1)'(Q_MIN[ENT_W-1:0])))
                begin
                    quo      <= Q_MIN;
                    flag.sat <= 1'b1;
                end
                else
                begin
                    quo      <= qneg[ENT_W-1:0];
                    flag.sat <= 1'b0;
                end
            end
            else
            begin
                if (big_reg[QB] || q_reg[QB][QB-1])
                begin
                    quo      <= Q_MAX;
                    flag.sat <= 1'b1;
                end
                else
                begin
                    quo      <= q_reg[QB][ENT_W-1:0];
                    flag.sat <= 1'b0;
                end
            end
        end
    end

endmodule

@@ rtl/matrix_inverse_3x3.sv @@
// Pipeline: 5 cofactor/determinant stages, then 27 divider stages (two set-up,
// one per quotient bit, one saturation stage).
// Throughput: one matrix per cycle; the whole pipeline holds while the output stalls.
// Reset clears only the valid bits; data registers are not reset.
// Top level of the 3x3 matrix inverse
`include "matrix_inverse_3x3_defines.svh"

module matrix_inverse_3x3
    import mi3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [NENT*ENT_W-1:0] s_tdata,   // in_r0c0, r0c1, r0c2, r1c0 .. r2c2
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [NENT*ENT_W-1:0] m_tdata,   // inv_r0c0, r0c1, r0c2, r1c0 .. r2c2
    output logic [1:0]            m_tuser    // singular, saturated
);

    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    logic signed [ENT_W-1:0] m [NENT];
    for (genvar i = 0; i < NENT; i++)
    begin : g_unpack
        assign m[i] = s_tdata[i*ENT_W +: ENT_W];
    end

    // stage 1: eighteen entry products
    logic signed [PROD_W-1:0] pk_reg [2*NENT];
    logic signed [ENT_W-1:0]  a1_reg, b1_reg, c1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pk_reg[0]  <= m[4] * m[8];  pk_reg[1]  <= m[5] * m[7];
            pk_reg[2]  <= m[2] * m[7];  pk_reg[3]  <= m[1] * m[8];
            pk_reg[4]  <= m[1] * m[5];  pk_reg[5]  <= m[2] * m[4];
            pk_reg[6]  <= m[5] * m[6];  pk_reg[7]  <= m[3] * m[8];
            pk_reg[8]  <= m[0] * m[8];  pk_reg[9]  <= m[2] * m[6];
            pk_reg[10] <= m[2] * m[3];  pk_reg[11] <= m[0] * m[5];
            pk_reg[12] <= m[3] * m[7];  pk_reg[13] <= m[4] * m[6];
            pk_reg[14] <= m[1] * m[6];  pk_reg[15] <= m[0] * m[7];
            pk_reg[16] <= m[0] * m[4];  pk_reg[17] <= m[1] * m[3];
            a1_reg <= m[0];
            b1_reg <= m[1];
            c1_reg <= m[2];
        end
    end

    // stage 2: cofactors
    logic signed [ADJ_W-1:0] adj2_reg [NENT];
    logic signed [ADJ_W-1:0] adj3_reg [NENT];
    logic signed [ADJ_W-1:0] adj4_reg [NENT];
    logic signed [ADJ_W-1:0] adj5_reg [NENT];
    logic signed [ENT_W-1:0] a2_reg, b2_reg, c2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NENT; j++)
                adj2_reg[j] <= ADJ_W'(pk_reg[2*j]) - ADJ_W'(pk_reg[2*j+1]);
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            c2_reg <= c1_reg;
        end
    end

    // stage 3: row 0 times first column of adjugate, each split into two partials
    logic signed [ENT_W-1:0] rowv [3];
    logic signed [ADJ_W-1:0] colv [3];
    logic signed [PART_W-1:0] phi_reg [3];
    logic signed [PART_W-1:0] plo_reg [3];

    assign rowv[0] = a2_reg;
    assign rowv[1] = b2_reg;
    assign rowv[2] = c2_reg;
    assign colv[0] = adj2_reg[0];
    assign colv[1] = adj2_reg[3];
    assign colv[2] = adj2_reg[6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                phi_reg[k] <= rowv[k] * $signed(colv[k][ADJ_W-1:SPLIT_W]);
                plo_reg[k] <= rowv[k] * $signed({1'b0, colv[k][SPLIT_W-1:0]});
            end
            adj3_reg <= adj2_reg;
        end
    end

    // stage 4: recombine partials; stage 5: determinant
    logic signed [DET_W-1:0] term_reg [3];
    logic signed [DET_W-1:0] det_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                term_reg[k] <= (DET_W'(phi_reg[k]) <<< SPLIT_W) + DET_W'(plo_reg[k]);
            adj4_reg <= adj3_reg;
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            adj5_reg <= adj4_reg;
        end
    end

    logic [NENT-1:0] sat_v;
    logic [NENT-1:0] zero_v;

    for (genvar i = 0; i < NENT; i++)
    begin : g_div
        logic signed [ENT_W-1:0] quo;
        mi3_flag_t               flag;

        mi3_div u_div (
            .clk  (clk),
            .en   (en),
            .adj  (adj5_reg[i]),
            .det  (det_reg),
            .quo  (quo),
            .flag (flag)
        );

        assign m_tdata[i*ENT_W +: ENT_W] = quo;
        assign sat_v[i]  = flag.sat;
        assign zero_v[i] = flag.zero;
    end

    assign m_tuser = {|sat_v, zero_v[0]};

    `MI3_ASSERT_IMP(a_ready_follows_out, 1'b1, s_tready == (!m_tvalid || m_tready))
    `MI3_ASSERT_IMP(a_singular_clean, m_tvalid && m_tuser[0], !m_tuser[1] && (m_tdata == '0))
    `MI3_ASSERT_NXT(a_last_stage_moves, vld_reg[LAT-2] && en, m_tvalid)

endmodule
